### src/slcc_pkg.sv
package slcc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LIST_COLORS_DEF = 7;
  localparam int unsigned LIST_IDX_W = 3;
  localparam int unsigned TABLE_LEN = 7;

  localparam logic [10:0] NEUTRAL_US = 11'd1500;
  localparam logic [15:0] PULSE_MIN = 16'd1000;
  localparam logic [15:0] PULSE_MAX = 16'd2000;
  localparam logic [16:0] SINCE_MAX = 17'h1FFFF;
  localparam logic [23:0] RESET_COLOR = 24'hFF0000;

  localparam logic [1:0] ORDER_GRB = 2'd0;
  localparam logic [1:0] ORDER_RGB = 2'd1;
  localparam logic [1:0] ORDER_BRG = 2'd2;

  localparam logic        WHEEL_MODE_RST = 1'b1;
  localparam logic [8:0]  HUE_STEP_RST = 9'd10;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd8;
  localparam logic [7:0]  DIM_PERIOD_RST = 8'd12;
  localparam logic [7:0]  DIM_ON_RST = 8'd1;
  localparam logic [15:0] ALIVE_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] STEP_PERIOD_RST = 16'd500;
  localparam logic [1:0]  COLOR_ORDER_RST = ORDER_RGB;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WHEEL_MODE    = 3'd0,
    CFG_HUE_STEP      = 3'd1,
    CFG_BRIGHTNESS    = 3'd2,
    CFG_DIM_PERIOD    = 3'd3,
    CFG_DIM_ON        = 3'd4,
    CFG_ALIVE_TIMEOUT = 3'd5,
    CFG_STEP_PERIOD   = 3'd6,
    CFG_COLOR_ORDER   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BYTE_HI  = 2'd0,
    BYTE_MID = 2'd1,
    BYTE_LO  = 2'd2
  } byte_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      update;
    logic      color;
    logic      scale;
    byte_sel_t scale_sel;
    logic      load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_cmd;
  } dp_status_t;

  function automatic logic [23:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [1:0] order);
    logic [23:0] w;
    case (order)
      ORDER_RGB: w = {r, g, b};
      ORDER_BRG: w = {b, r, g};
      default:   w = {g, r, b};
    endcase
    return w;
  endfunction

  function automatic logic [23:0] wheel_color(input logic [8:0] h, input logic [1:0] order);
    logic [2:0] sector;
    logic [5:0] f;
    logic [5:0] g;
    logic [9:0] rise_p;
    logic [9:0] fall_p;
    logic [7:0] rise;
    logic [7:0] fall;
    logic [7:0] r;
    logic [7:0] gr;
    logic [7:0] b;
    if (h < 9'd60) begin
      sector = 3'd0;
      f = h[5:0];
    end else if (h < 9'd120) begin
      sector = 3'd1;
      f = 6'(h - 9'd60);
    end else if (h < 9'd180) begin
      sector = 3'd2;
      f = 6'(h - 9'd120);
    end else if (h < 9'd240) begin
      sector = 3'd3;
      f = 6'(h - 9'd180);
    end else if (h < 9'd300) begin
      sector = 3'd4;
      f = 6'(h - 9'd240);
    end else begin
      sector = 3'd5;
      f = 6'(h - 9'd300);
    end
    // 255/60 is exactly 17/4.
    g = 6'(6'd60 - f);
    rise_p = 10'(f) * 10'd17;
    fall_p = (g == 6'd0) ? 10'd0 : 10'(g) * 10'd17;
    rise = rise_p[9:2];
    fall = (f == 6'd0) ? 8'd255 : fall_p[9:2];
    r = 8'd0;
    gr = 8'd0;
    b = 8'd0;
    case (sector)
      3'd0: begin r = 8'd255; gr = rise; end
      3'd1: begin r = fall; gr = 8'd255; end
      3'd2: begin gr = 8'd255; b = rise; end
      3'd3: begin gr = fall; b = 8'd255; end
      3'd4: begin r = rise; b = 8'd255; end
      default: begin r = 8'd255; b = fall; end
    endcase
    return pack_color(r, gr, b, order);
  endfunction

  function automatic logic [23:0] list_color(input logic [LIST_IDX_W-1:0] idx,
                                             input logic [1:0] order);
    logic [LIST_IDX_W-1:0] k;
    logic [23:0] rgb;
    k = (idx >= LIST_IDX_W'(TABLE_LEN)) ? LIST_IDX_W'(idx - LIST_IDX_W'(TABLE_LEN)) : idx;
    case (k)
      3'd0: rgb = {8'd255, 8'd0, 8'd0};
      3'd1: rgb = {8'd170, 8'd85, 8'd0};
      3'd2: rgb = {8'd128, 8'd127, 8'd0};
      3'd3: rgb = {8'd0, 8'd255, 8'd0};
      3'd4: rgb = {8'd0, 8'd0, 8'd255};
      3'd5: rgb = {8'd93, 8'd0, 8'd162};
      default: rgb = {8'd105, 8'd0, 8'd150};
    endcase
    return pack_color(rgb[23:16], rgb[15:8], rgb[7:0], order);
  endfunction

  function automatic logic [10:0] clamp_us(input logic [15:0] v);
    logic [10:0] c;
    if (v < PULSE_MIN) begin
      c = PULSE_MIN[10:0];
    end else if (v > PULSE_MAX) begin
      c = PULSE_MAX[10:0];
    end else begin
      c = v[10:0];
    end
    return c;
  endfunction

endpackage

### src/slcc_req_if.sv
interface slcc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] drive_cmd;
  logic [15:0] steer_cmd;

  modport source (output valid, req_type, drive_cmd, steer_cmd, input ready);
  modport sink (input valid, req_type, drive_cmd, steer_cmd, output ready);
endinterface

### src/slcc_res_if.sv
interface slcc_res_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [23:0] pixel_word;
  logic [10:0] drive_pulse;
  logic [10:0] steer_pulse;
  logic        link_alive;

  modport source (output valid, pixel_valid, pixel_word, drive_pulse, steer_pulse, link_alive,
                  input ready);
  modport sink (input valid, pixel_valid, pixel_word, drive_pulse, steer_pulse, link_alive,
                output ready);
endinterface

### src/status_led_color_cycler_watchdog_core.sv
// A tick item passes through the update, color, high, middle and low byte scale and
// load states; a command item only through update and load. The next item is taken
// once its result is loaded and the block is back in idle. The single 8x8 brightness
// multiplier is used once per color byte, after the counter update and color states.
// Synchronous active-high reset restores register defaults, neutral pulses, red color,
// the not-alive watchdog state and an empty output register.
module status_led_color_cycler_watchdog_core
  import slcc_pkg::*;
#(
  parameter int unsigned LIST_COLORS = LIST_COLORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  slcc_req_if.sink               req,
  slcc_res_if.source             res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  slcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  slcc_dp #(
    .LIST_COLORS (LIST_COLORS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req.req_type),
    .drive_cmd   (req.drive_cmd),
    .steer_cmd   (req.steer_cmd),
    .cmd         (cmd),
    .status      (status),
    .pixel_valid (res.pixel_valid),
    .pixel_word  (res.pixel_word),
    .drive_pulse (res.drive_pulse),
    .steer_pulse (res.steer_pulse),
    .link_alive  (res.link_alive)
  );

endmodule

### src/slcc_ctrl.sv
module slcc_ctrl
  import slcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_COLOR,
    S_SCALE_HI,
    S_SCALE_MID,
    S_SCALE_LO,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load_item = (state == S_IDLE) && in_valid;
    cmd.update = (state == S_UPDATE);
    cmd.color = (state == S_COLOR);
    cmd.scale = (state == S_SCALE_HI) || (state == S_SCALE_MID) || (state == S_SCALE_LO);
    cmd.scale_sel = (state == S_SCALE_MID) ? BYTE_MID :
                    (state == S_SCALE_LO) ? BYTE_LO : BYTE_HI;
    cmd.load_out = (state == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_LOAD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= status.is_cmd ? S_LOAD : S_COLOR;
        S_COLOR: state <= S_SCALE_HI;
        S_SCALE_HI: state <= S_SCALE_MID;
        S_SCALE_MID: state <= S_SCALE_LO;
        S_SCALE_LO: state <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/slcc_dp.sv
module slcc_dp
  import slcc_pkg::*;
#(
  parameter int unsigned LIST_COLORS = LIST_COLORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   req_type,
  input  logic [15:0]            drive_cmd,
  input  logic [15:0]            steer_cmd,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  output logic                   pixel_valid,
  output logic [23:0]            pixel_word,
  output logic [10:0]            drive_pulse,
  output logic [10:0]            steer_pulse,
  output logic                   link_alive
);

  logic        wheel_mode;
  logic [8:0]  hue_step;
  logic [7:0]  brightness;
  logic [7:0]  dim_period;
  logic [7:0]  dim_on;
  logic [15:0] alive_timeout;
  logic [15:0] step_period;
  logic [1:0]  color_order;

  logic        item_cmd;
  logic [15:0] item_drive;
  logic [15:0] item_steer;

  logic [7:0]            frame_phase;
  logic [16:0]           since_command;
  logic [15:0]           step_elapsed;
  logic [8:0]            hue;
  logic [LIST_IDX_W-1:0] list_index;
  logic [23:0]           current_color;
  logic [10:0]           drive_hold;
  logic [10:0]           steer_hold;
  logic                  alive;
  logic                  show;
  logic                  step;
  logic [23:0]           word;

  logic [8:0]            phase_inc;
  logic [7:0]            phase_next;
  logic                  show_next;
  logic [16:0]           since_next;
  logic                  alive_next;
  logic [16:0]           elapsed_inc;
  logic [9:0]            hue_sum;
  logic [8:0]            hue_next;
  logic [LIST_IDX_W:0]   list_inc;
  logic [LIST_IDX_W-1:0] list_next;
  logic [7:0]            scale_in;
  logic [15:0]           product;
  logic [15:0]           quot_sum;
  logic [7:0]            scaled;

  assign status.is_cmd = item_cmd;

  always_comb begin
    phase_inc = {1'b0, frame_phase} + 9'd1;
    if (dim_period == 8'd0) begin
      phase_next = 8'd0;
      show_next = 1'b1;
    end else begin
      phase_next = (phase_inc >= {1'b0, dim_period}) ? 8'd0 : phase_inc[7:0];
      show_next = phase_next < dim_on;
    end
    since_next = (since_command < SINCE_MAX) ? 17'(since_command + 17'd1) : since_command;
    alive_next = since_next <= {1'b0, alive_timeout};
    elapsed_inc = {1'b0, step_elapsed} + 17'd1;
    hue_sum = {1'b0, hue} + {1'b0, hue_step};
    if (hue_sum >= 10'd720) begin
      hue_next = 9'(hue_sum - 10'd720);
    end else if (hue_sum >= 10'd360) begin
      hue_next = 9'(hue_sum - 10'd360);
    end else begin
      hue_next = hue_sum[8:0];
    end
    list_inc = {1'b0, list_index} + (LIST_IDX_W+1)'(1);
    list_next = (list_inc >= (LIST_IDX_W+1)'(LIST_COLORS)) ? '0 : list_inc[LIST_IDX_W-1:0];
  end

  // Division by 255 of a product below 65536 as an add and shift.
  always_comb begin
    case (cmd.scale_sel)
      BYTE_MID: scale_in = current_color[15:8];
      BYTE_LO:  scale_in = current_color[7:0];
      default:  scale_in = current_color[23:16];
    endcase
    product = 16'(scale_in) * 16'(brightness);
    quot_sum = product + {8'd0, product[15:8]} + 16'd1;
    scaled = quot_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode <= WHEEL_MODE_RST;
      hue_step <= HUE_STEP_RST;
      brightness <= BRIGHTNESS_RST;
      dim_period <= DIM_PERIOD_RST;
      dim_on <= DIM_ON_RST;
      alive_timeout <= ALIVE_TIMEOUT_RST;
      step_period <= STEP_PERIOD_RST;
      color_order <= COLOR_ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WHEEL_MODE:    wheel_mode <= cfg_data[0];
        CFG_HUE_STEP:      hue_step <= cfg_data[8:0];
        CFG_BRIGHTNESS:    brightness <= cfg_data[7:0];
        CFG_DIM_PERIOD:    dim_period <= cfg_data[7:0];
        CFG_DIM_ON:        dim_on <= cfg_data[7:0];
        CFG_ALIVE_TIMEOUT: alive_timeout <= cfg_data;
        CFG_STEP_PERIOD:   step_period <= cfg_data;
        CFG_COLOR_ORDER:   color_order <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd <= req_type;
      item_drive <= drive_cmd;
      item_steer <= steer_cmd;
    end
    if (cmd.load_out) begin
      pixel_valid <= !item_cmd;
      pixel_word <= word;
      drive_pulse <= drive_hold;
      steer_pulse <= steer_hold;
      link_alive <= alive;
    end
    if (cmd.update) begin
      word <= '0;
    end else if (cmd.scale && show) begin
      case (cmd.scale_sel)
        BYTE_MID: word[15:8] <= scaled;
        BYTE_LO:  word[7:0] <= scaled;
        default:  word[23:16] <= scaled;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= '0;
      since_command <= SINCE_MAX;
      step_elapsed <= '0;
      hue <= '0;
      list_index <= '0;
      current_color <= RESET_COLOR;
      drive_hold <= NEUTRAL_US;
      steer_hold <= NEUTRAL_US;
      alive <= 1'b0;
      show <= 1'b0;
      step <= 1'b0;
    end else if (cmd.update) begin
      if (item_cmd) begin
        drive_hold <= clamp_us(item_drive);
        steer_hold <= clamp_us(item_steer);
        since_command <= '0;
        alive <= 1'b1;
        step <= 1'b0;
      end else begin
        frame_phase <= phase_next;
        show <= show_next;
        since_command <= since_next;
        alive <= alive_next;
        if (alive_next) begin
          if (elapsed_inc >= {1'b0, step_period}) begin
            step <= 1'b1;
            step_elapsed <= '0;
            if (wheel_mode) begin
              hue <= hue_next;
            end else begin
              list_index <= list_next;
            end
          end else begin
            step <= 1'b0;
            step_elapsed <= elapsed_inc[15:0];
          end
        end else begin
          step <= 1'b0;
          drive_hold <= NEUTRAL_US;
          steer_hold <= NEUTRAL_US;
        end
      end
    end else if (cmd.color && step) begin
      current_color <= wheel_mode ? wheel_color(hue, color_order)
                                  : list_color(list_index, color_order);
    end
  end

endmodule

### src/slcc_checker.sv
module slcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        pixel_valid,
  input logic [23:0] pixel_word,
  input logic [10:0] drive_pulse,
  input logic [10:0] steer_pulse,
  input logic        link_alive
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pixel_word))
    else $error("result item dropped or changed while stalled");

  a_cmd_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && !pixel_valid |-> pixel_word == 24'd0 && link_alive)
    else $error("command result carries a pixel word or a dead link");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> drive_pulse >= 11'd1000 && drive_pulse <= 11'd2000 &&
                  steer_pulse >= 11'd1000 && steer_pulse <= 11'd2000)
    else $error("pulse width out of range");

  a_dead_neutral: assert property (@(posedge clk) disable iff (rst)
    res_valid && !link_alive |-> drive_pulse == 11'd1500 && steer_pulse == 11'd1500)
    else $error("pulses not neutral while link is down");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind status_led_color_cycler_watchdog_core slcc_checker u_slcc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .pixel_valid (res.pixel_valid),
  .pixel_word  (res.pixel_word),
  .drive_pulse (res.drive_pulse),
  .steer_pulse (res.steer_pulse),
  .link_alive  (res.link_alive)
);
